// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file mmd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mmd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmd_pkg
// Types and constants of the multi-level min/max decimator.
// ----------------------------------------------------------------------------
package mmd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int LEVEL_W       = 2;
    localparam int BUCKET_NUM_W  = 24;
    localparam int FILL_W        = 16;
    localparam int SIZE_W        = 17;
    localparam int NUM_REGS      = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SIZE_W-1:0] MAX_BUCKET = SIZE_W'(65536);
    localparam logic [SIZE_W-1:0] MIN_BUCKET = SIZE_W'(1);

    localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_REGS] = '{
        SIZE_W'(64), SIZE_W'(256), SIZE_W'(1024), SIZE_W'(4096)
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic        [LEVEL_W-1:0]      level;
        logic        [BUCKET_NUM_W-1:0] bucket_number;
        logic signed [SAMPLE_BITS-1:0]  bucket_min;
        logic        [SAMPLE_BITS-2:0]  bucket_max;
        logic                           last_of_run;
    } t_out_word;

    typedef struct packed {
        logic        [BUCKET_NUM_W-1:0] bucket_number;
        logic signed [SAMPLE_BITS-1:0]  bucket_min;
        logic        [SAMPLE_BITS-2:0]  bucket_max;
    } t_level_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/multi_level_min_max_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// multi_level_min_max_decimator_unit
// Min/max overview of a sample stream at several zoom levels in parallel.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in_word  (t_in_word)
//   out       output     o_out_valid / i_out_ready o_out_word (t_out_word)
//   cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One sample is taken per cycle while the queue is not full; all levels update in the same cycle.
// A sample that closes k buckets gives k result words, which the output register
// issues one word per cycle while the output is not stalled.
// A two-entry queue separates the level update from the result issue.
// Synchronous reset restores the reset bucket sizes and clears all levels.
// A stalled output stops intake only once the queue is full.
// ----------------------------------------------------------------------------
module multi_level_min_max_decimator_unit
    import mmd_pkg::*;
#(
    parameter int NUM_LEVELS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_word              o_out_word
);

    localparam int ENTRY_W = NUM_LEVELS * ($bits(t_level_result) + 1);

    logic                            fire;
    logic                            push;
    logic                            pop;
    logic [NUM_LEVELS-1:0]           front_mask;
    t_level_result [NUM_LEVELS-1:0]  front_results;
    logic [NUM_LEVELS-1:0]           head_mask;
    t_level_result [NUM_LEVELS-1:0]  head_results;
    logic [ENTRY_W-1:0]              head;
    t_q_status                       q_status;

    assign o_in_ready = !q_status.full;
    assign fire       = i_in_valid && o_in_ready;

    mmd_front #(.NUM_LEVELS(NUM_LEVELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_word      (i_in_word),
        .o_push      (push),
        .o_mask      (front_mask),
        .o_results   (front_results)
    );

    mmd_queue #(.WIDTH(ENTRY_W)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({front_mask, front_results}),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    assign {head_mask, head_results} = head;

    mmd_back #(.NUM_LEVELS(NUM_LEVELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask      (head_mask),
        .i_results   (head_results),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== design/mmd_front.sv =====
// ----------------------------------------------------------------------------
// mmd_front
// Bucket size registers and per-level running state; classifies each sample
// into the set of levels whose bucket closes.
// ----------------------------------------------------------------------------
module mmd_front
    import mmd_pkg::*;
#(
    parameter int NUM_LEVELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]           i_cfg_index,
    input  logic [SIZE_W-1:0]                i_cfg_data,
    input  logic                             i_fire,
    input  t_in_word                         i_word,
    output logic                             o_push,
    output logic [NUM_LEVELS-1:0]            o_mask,
    output t_level_result [NUM_LEVELS-1:0]   o_results
);

    function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] d);
        logic [SIZE_W-1:0] s;
        s = d;
        if (d == '0) begin
            s = MIN_BUCKET;
        end else if (d > MAX_BUCKET) begin
            s = MAX_BUCKET;
        end
        return s;
    endfunction

    logic [SIZE_W-1:0] r_size [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_size[k] <= SIZE_RESET[k];
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_INDEX_W'(NUM_REGS))) begin
            r_size[i_cfg_index[$clog2(NUM_REGS)-1:0]] <= effective_size(i_cfg_data);
        end
    end

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
        localparam int REG_IDX = (g < NUM_REGS) ? g : NUM_REGS - 1;

        logic        [FILL_W-1:0]       r_fill;
        logic signed [SAMPLE_BITS-1:0]  r_min;
        logic        [SAMPLE_BITS-2:0]  r_max;
        logic        [BUCKET_NUM_W-1:0] r_count;

        logic signed [SAMPLE_BITS-1:0]  max_ext;
        logic signed [SAMPLE_BITS-1:0]  n_min;
        logic        [SAMPLE_BITS-2:0]  n_max;
        logic        [SIZE_W-1:0]       fill_inc;
        logic                           close;

        always_comb begin
            max_ext  = $signed({1'b0, r_max});
            n_min    = (i_word.sample < r_min) ? i_word.sample : r_min;
            n_max    = (i_word.sample > max_ext) ? i_word.sample[SAMPLE_BITS-2:0] : r_max;
            fill_inc = {1'b0, r_fill} + SIZE_W'(1);
            close    = (fill_inc >= r_size[REG_IDX]) || i_word.end_of_stream;
        end

        assign o_mask[g]                   = close;
        assign o_results[g].bucket_number  = r_count;
        assign o_results[g].bucket_min     = n_min;
        assign o_results[g].bucket_max     = n_max;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fill  <= '0;
                r_min   <= '0;
                r_max   <= '0;
                r_count <= '0;
            end else if (i_fire) begin
                if (close) begin
                    r_fill  <= '0;
                    r_min   <= '0;
                    r_max   <= '0;
                    r_count <= i_word.end_of_stream ? '0 : r_count + BUCKET_NUM_W'(1);
                end else begin
                    r_fill  <= fill_inc[FILL_W-1:0];
                    r_min   <= n_min;
                    r_max   <= n_max;
                end
            end
        end
    end

    assign o_push = i_fire && (|o_mask);

endmodule

// ===== design/mmd_queue.sv =====
// ----------------------------------------------------------------------------
// mmd_queue
// Short first-in first-out queue of closed-bucket sets between front and back.
// ----------------------------------------------------------------------------
module mmd_queue
    import mmd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output t_q_status        o_status
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== design/mmd_back.sv =====
// ----------------------------------------------------------------------------
// mmd_back
// Walks the closed levels of the queue head in ascending order and issues one
// result word per cycle through the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module mmd_back
    import mmd_pkg::*;
#(
    parameter int NUM_LEVELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [NUM_LEVELS-1:0]            i_mask,
    input  t_level_result [NUM_LEVELS-1:0]   i_results,
    input  t_q_status                        i_status,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output t_out_word                        o_out_word
);

    logic [NUM_LEVELS-1:0] r_sent;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  load;
    logic [NUM_LEVELS-1:0] pending;
    logic [NUM_LEVELS-1:0] sel_bit;
    logic [NUM_LEVELS-1:0] rest;
    logic [LEVEL_W-1:0]    sel_level;
    t_level_result         sel_result;

    always_comb begin
        load       = !r_out_valid || i_out_ready;
        pending    = i_mask & ~r_sent & {NUM_LEVELS{!i_status.empty}};
        sel_bit    = '0;
        sel_level  = '0;
        sel_result = i_results[0];
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (pending[i]) begin
                sel_bit    = NUM_LEVELS'(1) << i;
                sel_level  = LEVEL_W'(i);
                sel_result = i_results[i];
            end
        end
        rest  = pending & ~sel_bit;
        o_pop = load && (|pending) && (rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= |pending;
            if (o_pop) begin
                r_sent <= '0;
            end else if (|pending) begin
                r_sent <= r_sent | sel_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && (|pending)) begin
            r_out_word.level         <= sel_level;
            r_out_word.bucket_number <= sel_result.bucket_number;
            r_out_word.bucket_min    <= sel_result.bucket_min;
            r_out_word.bucket_max    <= sel_result.bucket_max;
            r_out_word.last_of_run   <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== design/mmd_checker.sv =====
// ----------------------------------------------------------------------------
// mmd_checker
// Port-level checks of the decimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmd_checker
    import mmd_pkg::*;
#(
    parameter int NUM_LEVELS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word
);

    logic taken_mid_run;

    assign taken_mid_run = i_out_valid && i_out_ready && !i_out_word.last_of_run;

    `MMD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word), "Stalled result word changed or dropped")

    `MMD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "Result word valid right after reset")

    `MMD_ASSERT(a_run_continues, i_clk, i_rst_n, taken_mid_run |=> i_out_valid, "Gap inside a run of result words")

    if (NUM_LEVELS <= 4) begin : g_order
        `MMD_ASSERT(a_level_order, i_clk, i_rst_n, taken_mid_run |=> i_out_word.level > $past(i_out_word.level), "Levels within a run not ascending")
    end

endmodule

bind multi_level_min_max_decimator_unit mmd_checker #(.NUM_LEVELS(NUM_LEVELS)) u_mmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);
